@@ rtl/rba_pkg.sv @@
package rba_pkg;

	// File geometry; block sizes are powers of two
	localparam int INT_BLOCK_REGS = 32;
	localparam int FLT_BLOCK_REGS = 32;
	localparam int INT_FILE_REGS  = 1024;
	localparam int FLT_FILE_REGS  = 1024;

	localparam int INT_NBLK  = INT_FILE_REGS / INT_BLOCK_REGS;
	localparam int FLT_NBLK  = FLT_FILE_REGS / FLT_BLOCK_REGS;
	localparam int MAX_NBLK  = (INT_NBLK > FLT_NBLK) ? INT_NBLK : FLT_NBLK;
	localparam int INT_SH    = $clog2(INT_BLOCK_REGS);
	localparam int FLT_SH    = $clog2(FLT_BLOCK_REGS);
	localparam int INT_IDX_W = $clog2(INT_NBLK);
	localparam int FLT_IDX_W = $clog2(FLT_NBLK);

	// block position, run length and pool count all fit 0..MAX_NBLK
	localparam int POS_W = $clog2(MAX_NBLK + 1);
	// common width for compares between needs, pools and positions
	localparam int CMP_W = 24;
	localparam int FC_W  = 6;
	localparam int FC_MAX = 63;

	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_FREE    = 2'd1;
	localparam logic [1:0] FUNC_RESERVE = 2'd2;

	localparam logic [1:0] CTX_NORMAL    = 2'd0;
	localparam logic [1:0] CTX_RESERVED  = 2'd1;
	localparam logic [1:0] CTX_EXCLUSIVE = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [10:0] int_request_regs;
		logic [10:0] flt_request_regs;
		logic [7:0]  family_id;
		logic [1:0]  context_kind;
		logic [9:0]  int_release_base;
		logic        int_release_valid;
		logic [9:0]  flt_release_base;
		logic        flt_release_valid;
	} rba_in_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [9:0]      int_base;
		logic            int_base_valid;
		logic [9:0]      flt_base;
		logic            flt_base_valid;
		logic [FC_W-1:0] free_contexts;
	} rba_out_t;

	typedef struct packed {
		logic load;
		logic start;
		logic commit;
	} rba_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} rba_sts_t;

endpackage

@@ rtl/rba_scan.sv @@
module rba_scan
	import rba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             enable,
	input  logic [CMP_W-1:0] need,
	input  logic [CMP_W-1:0] avail,
	input  logic [CMP_W-1:0] nblk,
	input  logic [POS_W-1:0] len,
	output logic [POS_W-1:0] pos,
	output logic             busy,
	output logic             done,
	output logic             found,
	output logic [POS_W-1:0] head
);

	logic [POS_W-1:0] pos_q, start_q, cnt_q, head_q;
	logic             in_run_q, busy_q, done_q, found_q;
	logic [POS_W-1:0] cnt_nxt, head_nxt;
	logic             fail, hit;

	// one table entry per cycle: skip a used run by its length, else grow the free run
	always_comb begin
		cnt_nxt  = in_run_q ? POS_W'(cnt_q + 1'b1) : POS_W'(1);
		head_nxt = in_run_q ? start_q : pos_q;
		fail     = (avail < need) || (CMP_W'(pos_q) >= nblk);
		hit      = (len == '0) && (CMP_W'(cnt_nxt) == need);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			start_q  <= '0;
			cnt_q    <= '0;
			head_q   <= '0;
			in_run_q <= 1'b0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
		end else if (start) begin
			pos_q    <= '0;
			cnt_q    <= '0;
			in_run_q <= 1'b0;
			found_q  <= 1'b0;
			busy_q   <= enable;
			done_q   <= !enable;
		end else if (busy_q) begin
			if (fail) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else if (len != '0) begin
				pos_q    <= POS_W'(pos_q + len);
				in_run_q <= 1'b0;
			end else if (hit) begin
				busy_q  <= 1'b0;
				done_q  <= 1'b1;
				found_q <= 1'b1;
				head_q  <= head_nxt;
			end else begin
				pos_q    <= POS_W'(pos_q + 1'b1);
				cnt_q    <= cnt_nxt;
				start_q  <= head_nxt;
				in_run_q <= 1'b1;
			end
		end
	end

	assign pos   = pos_q;
	assign busy  = busy_q;
	assign done  = done_q;
	assign found = found_q;
	assign head  = head_q;

endmodule

@@ rtl/rba_ctrl.sv @@
module rba_ctrl
	import rba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rba_sts_t sts,
	output rba_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = in_valid && (state_q == S_IDLE);
	assign cmd.start  = (state_q == S_START);
	// result register must be empty or emptying this cycle
	assign cmd.commit = (state_q == S_COMMIT) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_START;
				end
				S_START: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_done) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/rba_dp.sv @@
module rba_dp
	import rba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rba_cmd_t cmd,
	output rba_sts_t sts,
	input  rba_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rba_out_t out_data
);

	rba_in_t          item_q;
	logic [CMP_W-1:0] ineed_q, fneed_q;

	logic [POS_W-1:0] ilen_q [INT_NBLK];
	logic [POS_W-1:0] flen_q [FLT_NBLK];
	logic [7:0]       iown_q [INT_NBLK];
	logic [7:0]       fown_q [FLT_NBLK];

	logic [POS_W-1:0] inorm_q, ires_q, fnorm_q, fres_q;
	logic             iexc_q, fexc_q;

	logic             out_valid_q;
	rba_out_t         out_q;

	// item decode
	logic             ireq_nz, freq_nz, ctx_bad, extra, excl, alloc_ok;
	logic [CMP_W-1:0] iavail, favail;
	logic [CMP_W-1:0] ii_full, fi_full;
	logic             ii_ok, fi_ok;
	logic [POS_W-1:0] ii_pos, fi_pos;

	// scanners
	logic [POS_W-1:0] ipos, fpos, ihead, fhead;
	logic             ibusy, fbusy, idone, fdone, ifound, ffound;

	// table reads
	logic [POS_W-1:0] iaddr, faddr, ilen_rd, flen_rd;

	// commit
	logic [1:0]       status;
	logic             ivalid, fvalid, iwr, fwr;
	logic [INT_IDX_W-1:0] iwr_idx;
	logic [FLT_IDX_W-1:0] fwr_idx;
	logic [POS_W-1:0] iwr_val, fwr_val;
	logic [POS_W-1:0] inorm_n, ires_n, fnorm_n, fres_n;
	logic             iexc_n, fexc_n;
	logic             ispec_zero, fspec_zero, ipool_bad, fpool_bad;
	logic [CMP_W-1:0] ibase_full, fbase_full;
	logic [POS_W-1:0] fc_min;
	rba_out_t         res;

	always_comb begin
		ireq_nz  = (item_q.int_request_regs != '0);
		freq_nz  = (item_q.flt_request_regs != '0);
		ctx_bad  = (item_q.context_kind != CTX_NORMAL) &&
		           (item_q.context_kind != CTX_RESERVED) &&
		           (item_q.context_kind != CTX_EXCLUSIVE);
		extra    = (item_q.context_kind != CTX_NORMAL);
		excl     = (item_q.context_kind == CTX_EXCLUSIVE);
		alloc_ok = (item_q.func == FUNC_ALLOC) && !ctx_bad;
		iavail   = CMP_W'(inorm_q) + CMP_W'(extra);
		favail   = CMP_W'(fnorm_q) + CMP_W'(extra);
		ii_full  = CMP_W'(item_q.int_release_base) >> INT_SH;
		fi_full  = CMP_W'(item_q.flt_release_base) >> FLT_SH;
		ii_ok    = (ii_full < CMP_W'(INT_NBLK));
		fi_ok    = (fi_full < CMP_W'(FLT_NBLK));
		ii_pos   = POS_W'(ii_full);
		fi_pos   = POS_W'(fi_full);
	end

	rba_scan u_iscan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.enable (alloc_ok && ireq_nz),
		.need   (ineed_q),
		.avail  (iavail),
		.nblk   (CMP_W'(INT_NBLK)),
		.len    (ilen_rd),
		.pos    (ipos),
		.busy   (ibusy),
		.done   (idone),
		.found  (ifound),
		.head   (ihead)
	);

	rba_scan u_fscan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.enable (alloc_ok && freq_nz),
		.need   (fneed_q),
		.avail  (favail),
		.nblk   (CMP_W'(FLT_NBLK)),
		.len    (flen_rd),
		.pos    (fpos),
		.busy   (fbusy),
		.done   (fdone),
		.found  (ffound),
		.head   (fhead)
	);

	// one read port per table: scan position while scanning, release block otherwise
	always_comb begin
		iaddr   = ibusy ? ipos : ii_pos;
		faddr   = fbusy ? fpos : fi_pos;
		ilen_rd = (CMP_W'(iaddr) < CMP_W'(INT_NBLK)) ? ilen_q[iaddr[INT_IDX_W-1:0]] : '0;
		flen_rd = (CMP_W'(faddr) < CMP_W'(FLT_NBLK)) ? flen_q[faddr[FLT_IDX_W-1:0]] : '0;
	end

	always_comb begin
		status  = ST_DONE;
		ivalid  = 1'b0;
		fvalid  = 1'b0;
		iwr     = 1'b0;
		fwr     = 1'b0;
		iwr_idx = ihead[INT_IDX_W-1:0];
		fwr_idx = fhead[FLT_IDX_W-1:0];
		iwr_val = POS_W'(ineed_q);
		fwr_val = POS_W'(fneed_q);
		inorm_n = inorm_q;
		ires_n  = ires_q;
		iexc_n  = iexc_q;
		fnorm_n = fnorm_q;
		fres_n  = fres_q;
		fexc_n  = fexc_q;
		ispec_zero = (item_q.context_kind == CTX_RESERVED) ? (ires_q == '0) : !iexc_q;
		fspec_zero = (item_q.context_kind == CTX_RESERVED) ? (fres_q == '0) : !fexc_q;
		ipool_bad = ireq_nz && ((extra && ispec_zero) ||
		            (CMP_W'(inorm_q) < ineed_q - CMP_W'(extra)));
		fpool_bad = freq_nz && ((extra && fspec_zero) ||
		            (CMP_W'(fnorm_q) < fneed_q - CMP_W'(extra)));
		case (item_q.func)
			FUNC_ALLOC: begin
				if (ctx_bad) begin
					status = ST_ERROR;
				end else if ((ireq_nz && !ifound) || (freq_nz && !ffound)) begin
					status = ST_NO_SPACE;
				end else if (ipool_bad || fpool_bad) begin
					status = ST_ERROR;
				end else begin
					if (ireq_nz) begin
						iwr    = 1'b1;
						ivalid = 1'b1;
						if (extra) begin
							if (item_q.context_kind == CTX_RESERVED)
								ires_n = POS_W'(ires_q - 1'b1);
							else
								iexc_n = 1'b0;
						end
						inorm_n = POS_W'(CMP_W'(inorm_q) - (ineed_q - CMP_W'(extra)));
					end
					if (freq_nz) begin
						fwr    = 1'b1;
						fvalid = 1'b1;
						if (extra) begin
							if (item_q.context_kind == CTX_RESERVED)
								fres_n = POS_W'(fres_q - 1'b1);
							else
								fexc_n = 1'b0;
						end
						fnorm_n = POS_W'(CMP_W'(fnorm_q) - (fneed_q - CMP_W'(extra)));
					end
				end
			end
			FUNC_FREE: begin
				if (ctx_bad ||
				    (item_q.int_release_valid &&
				     (!ii_ok || ilen_rd == '0 || (excl && iexc_q))) ||
				    (item_q.flt_release_valid &&
				     (!fi_ok || flen_rd == '0 || (excl && fexc_q)))) begin
					status = ST_ERROR;
				end else begin
					// exclusive context hands one block back to its own pool
					if (item_q.int_release_valid) begin
						iwr     = 1'b1;
						iwr_idx = ii_pos[INT_IDX_W-1:0];
						iwr_val = '0;
						inorm_n = POS_W'(inorm_q + ilen_rd - POS_W'(excl));
						if (excl) iexc_n = 1'b1;
					end
					if (item_q.flt_release_valid) begin
						fwr     = 1'b1;
						fwr_idx = fi_pos[FLT_IDX_W-1:0];
						fwr_val = '0;
						fnorm_n = POS_W'(fnorm_q + flen_rd - POS_W'(excl));
						if (excl) fexc_n = 1'b1;
					end
				end
			end
			FUNC_RESERVE: begin
				if (inorm_q == '0 || fnorm_q == '0) begin
					status = ST_ERROR;
				end else begin
					inorm_n = POS_W'(inorm_q - 1'b1);
					ires_n  = POS_W'(ires_q + 1'b1);
					fnorm_n = POS_W'(fnorm_q - 1'b1);
					fres_n  = POS_W'(fres_q + 1'b1);
				end
			end
			default: begin
				status = ST_ERROR;
			end
		endcase
	end

	always_comb begin
		ibase_full = CMP_W'(ihead) << INT_SH;
		fbase_full = CMP_W'(fhead) << FLT_SH;
		fc_min     = (inorm_n < fnorm_n) ? inorm_n : fnorm_n;
		res.status         = status;
		res.int_base       = ivalid ? ibase_full[9:0] : '0;
		res.int_base_valid = ivalid;
		res.flt_base       = fvalid ? fbase_full[9:0] : '0;
		res.flt_base_valid = fvalid;
		res.free_contexts  = (CMP_W'(fc_min) > CMP_W'(FC_MAX)) ? FC_W'(FC_MAX) : FC_W'(fc_min);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= in_data;
			ineed_q <= (CMP_W'(in_data.int_request_regs) + CMP_W'(INT_BLOCK_REGS - 1)) >> INT_SH;
			fneed_q <= (CMP_W'(in_data.flt_request_regs) + CMP_W'(FLT_BLOCK_REGS - 1)) >> FLT_SH;
		end
		if (cmd.commit && ivalid) iown_q[ihead[INT_IDX_W-1:0]] <= item_q.family_id;
		if (cmd.commit && fvalid) fown_q[fhead[FLT_IDX_W-1:0]] <= item_q.family_id;
		if (cmd.commit) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < INT_NBLK; k++) ilen_q[k] <= '0;
			for (int k = 0; k < FLT_NBLK; k++) flen_q[k] <= '0;
			inorm_q     <= POS_W'(INT_NBLK - 1);
			ires_q      <= '0;
			iexc_q      <= 1'b1;
			fnorm_q     <= POS_W'(FLT_NBLK - 1);
			fres_q      <= '0;
			fexc_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (iwr) ilen_q[iwr_idx] <= iwr_val;
				if (fwr) flen_q[fwr_idx] <= fwr_val;
				inorm_q     <= inorm_n;
				ires_q      <= ires_n;
				iexc_q      <= iexc_n;
				fnorm_q     <= fnorm_n;
				fres_q      <= fres_n;
				fexc_q      <= fexc_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.scan_done = idone && fdone;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	// pool tokens plus allocated blocks equal the block count; checked as tokens never exceeding it
	a_int_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(inorm_q) + CMP_W'(ires_q) + CMP_W'(iexc_q) <= CMP_W'(INT_NBLK))
		else $error("int pool tokens exceed block count");

	a_flt_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fnorm_q) + CMP_W'(fres_q) + CMP_W'(fexc_q) <= CMP_W'(FLT_NBLK))
		else $error("flt pool tokens exceed block count");

	a_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (idone && fdone && !ibusy && !fbusy))
		else $error("commit while a scan is running");

	a_base_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.int_base_valid || out_q.flt_base_valid) |->
		out_q.status == ST_DONE)
		else $error("base reported on a failed step");

endmodule

@@ rtl/register_block_allocator.sv @@
// Contiguous register block allocator for an integer and a float register file, each cut
// into fixed blocks. One command at a time: allocate (first-fit over the block table of
// each file, both committed or neither), free, or reserve one context. Each command
// passes through the idle, start, scan and commit states; the scan state runs the
// first-fit scan for allocate, which visits one table entry per cycle in both files at
// once, and commit waits until the output register is free. The result sits in an
// output register, so the scan of the next command can run while it waits.
module register_block_allocator
	import rba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rba_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rba_out_t out_data
);

	rba_cmd_t cmd;
	rba_sts_t sts;

	rba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ dv/tb_register_block_allocator.sv @@
module tb_register_block_allocator;
	import rba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam logic [1:0] CTX_UNKNOWN  = 2'd3;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	rba_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	rba_out_t out_data;

	register_block_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	// shadow of the block tables and pools
	logic [POS_W-1:0] int_run_len [MAX_NBLK];
	logic [POS_W-1:0] flt_run_len [MAX_NBLK];
	logic [1:0]       int_run_ctx [MAX_NBLK];
	logic [1:0]       flt_run_ctx [MAX_NBLK];
	int               int_normal, int_rsv, int_excl;
	int               flt_normal, flt_rsv, flt_excl;

	rba_out_t expected_results [$];
	int       mismatches = 0;
	bit       calm = 1'b0;
	logic [2:0] rx_hold = '0;

	function automatic bit ctx_known(input logic [1:0] ctx);
		return ctx == CTX_NORMAL || ctx == CTX_RESERVED || ctx == CTX_EXCLUSIVE;
	endfunction

	// first-fit over one file; used runs are skipped by their length
	function automatic int first_fit(input bit is_flt, input int need, input int avail);
		int nblk;
		int pos;
		int start;
		int len;
		nblk = is_flt ? FLT_NBLK : INT_NBLK;
		pos = 0;
		if (avail < need)
			return -1;
		while (pos < nblk) begin
			len = is_flt ? flt_run_len[pos] : int_run_len[pos];
			if (len != 0) begin
				pos += len;
			end else begin
				start = pos;
				while (pos < nblk && (is_flt ? flt_run_len[pos] : int_run_len[pos]) == 0) begin
					if (pos - start + 1 == need)
						return start;
					pos++;
				end
			end
		end
		return -1;
	endfunction

	function automatic int special_pool(input bit is_flt, input logic [1:0] ctx);
		if (is_flt)
			return (ctx == CTX_RESERVED) ? flt_rsv : flt_excl;
		return (ctx == CTX_RESERVED) ? int_rsv : int_excl;
	endfunction

	function automatic rba_out_t predict_outcome(input rba_in_t it);
		rba_out_t r;
		int ineed, fneed, extra, ihead, fhead, ii, fi, n, fc;
		bit excl;
		logic [1:0] ctx;
		r = '0;
		ctx = it.context_kind;
		ihead = -1;
		fhead = -1;
		case (it.func)
			FUNC_ALLOC: begin
				ineed = (int'(it.int_request_regs) + INT_BLOCK_REGS - 1) / INT_BLOCK_REGS;
				fneed = (int'(it.flt_request_regs) + FLT_BLOCK_REGS - 1) / FLT_BLOCK_REGS;
				extra = (ctx != CTX_NORMAL) ? 1 : 0;
				if (!ctx_known(ctx)) begin
					r.status = ST_ERROR;
				end else begin
					if (ineed != 0) begin
						ihead = first_fit(1'b0, ineed, int_normal + extra);
						if (ihead < 0)
							r.status = ST_NO_SPACE;
					end
					// integer failure ends the step before the float search
					if (r.status == ST_DONE && fneed != 0) begin
						fhead = first_fit(1'b1, fneed, flt_normal + extra);
						if (fhead < 0)
							r.status = ST_NO_SPACE;
					end
					if (r.status == ST_DONE) begin
						if (ineed != 0 && ((extra != 0 && special_pool(1'b0, ctx) == 0) ||
								int_normal < ineed - extra))
							r.status = ST_ERROR;
						if (fneed != 0 && ((extra != 0 && special_pool(1'b1, ctx) == 0) ||
								flt_normal < fneed - extra))
							r.status = ST_ERROR;
					end
					if (r.status == ST_DONE) begin
						if (ineed != 0) begin
							int_run_len[ihead] = POS_W'(ineed);
							int_run_ctx[ihead] = ctx;
							if (extra != 0) begin
								if (ctx == CTX_RESERVED)
									int_rsv--;
								else
									int_excl--;
							end
							int_normal -= ineed - extra;
							r.int_base = 10'(ihead * INT_BLOCK_REGS);
							r.int_base_valid = 1'b1;
						end
						if (fneed != 0) begin
							flt_run_len[fhead] = POS_W'(fneed);
							flt_run_ctx[fhead] = ctx;
							if (extra != 0) begin
								if (ctx == CTX_RESERVED)
									flt_rsv--;
								else
									flt_excl--;
							end
							flt_normal -= fneed - extra;
							r.flt_base = 10'(fhead * FLT_BLOCK_REGS);
							r.flt_base_valid = 1'b1;
						end
					end
				end
			end
			FUNC_FREE: begin
				ii = int'(it.int_release_base) / INT_BLOCK_REGS;
				fi = int'(it.flt_release_base) / FLT_BLOCK_REGS;
				excl = (ctx == CTX_EXCLUSIVE);
				if (!ctx_known(ctx))
					r.status = ST_ERROR;
				if (it.int_release_valid && (ii >= INT_NBLK || int_run_len[ii] == 0 ||
						(excl && int_excl != 0)))
					r.status = ST_ERROR;
				if (it.flt_release_valid && (fi >= FLT_NBLK || flt_run_len[fi] == 0 ||
						(excl && flt_excl != 0)))
					r.status = ST_ERROR;
				if (r.status == ST_DONE) begin
					if (it.int_release_valid) begin
						n = int_run_len[ii];
						if (excl) begin
							int_excl++;
							n--;
						end
						int_normal += n;
						int_run_len[ii] = '0;
					end
					if (it.flt_release_valid) begin
						n = flt_run_len[fi];
						if (excl) begin
							flt_excl++;
							n--;
						end
						flt_normal += n;
						flt_run_len[fi] = '0;
					end
				end
			end
			FUNC_RESERVE: begin
				if (int_normal == 0 || flt_normal == 0) begin
					r.status = ST_ERROR;
				end else begin
					int_normal--;
					int_rsv++;
					flt_normal--;
					flt_rsv++;
				end
			end
			default: r.status = ST_ERROR;
		endcase
		fc = (int_normal < flt_normal) ? int_normal : flt_normal;
		if (fc > FC_MAX)
			fc = FC_MAX;
		r.free_contexts = FC_W'(fc);
		return r;
	endfunction

	// ---- stimulus construction ----

	function automatic rba_in_t random_cmd();
		rba_in_t it;
		it.func              = 2'($urandom_range(0, 3));
		it.int_request_regs  = 11'($urandom_range(0, 2047));
		it.flt_request_regs  = 11'($urandom_range(0, 2047));
		it.family_id         = 8'($urandom_range(0, 255));
		it.context_kind      = 2'($urandom_range(0, 3));
		it.int_release_base  = 10'($urandom_range(0, 1023));
		it.int_release_valid = 1'($urandom_range(0, 1));
		it.flt_release_base  = 10'($urandom_range(0, 1023));
		it.flt_release_valid = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic rba_in_t alloc_cmd(input logic [1:0] ctx, input int ireq, input int freq);
		rba_in_t it;
		it = random_cmd();
		it.func = FUNC_ALLOC;
		it.context_kind = ctx;
		it.int_request_regs = 11'(ireq);
		it.flt_request_regs = 11'(freq);
		return it;
	endfunction

	function automatic rba_in_t release_cmd(input logic [1:0] ctx, input int ibase, input bit ival,
			input int fbase, input bit fval);
		rba_in_t it;
		it = random_cmd();
		it.func = FUNC_FREE;
		it.context_kind = ctx;
		it.int_release_base = 10'(ibase);
		it.int_release_valid = ival;
		it.flt_release_base = 10'(fbase);
		it.flt_release_valid = fval;
		return it;
	endfunction

	function automatic rba_in_t reserve_cmd();
		rba_in_t it;
		it = random_cmd();
		it.func = FUNC_RESERVE;
		return it;
	endfunction

	// random run head of one file, -1 when the file is empty
	function automatic int pick_head(input bit is_flt);
		int nblk, cnt, k, b;
		nblk = is_flt ? FLT_NBLK : INT_NBLK;
		cnt = 0;
		for (b = 0; b < nblk; b++)
			if ((is_flt ? flt_run_len[b] : int_run_len[b]) != 0)
				cnt++;
		if (cnt == 0)
			return -1;
		k = $urandom_range(0, cnt - 1);
		for (b = 0; b < nblk; b++) begin
			if ((is_flt ? flt_run_len[b] : int_run_len[b]) != 0) begin
				if (k == 0)
					return b;
				k--;
			end
		end
		return -1;
	endfunction

	// mostly small requests, now and then most of a file
	function automatic int request_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 0;
		if (r < 7)
			return $urandom_range(1, 96);
		if (r < 9)
			return $urandom_range(97, 320);
		return $urandom_range(321, 1024);
	endfunction

	function automatic rba_in_t traffic_cmd();
		int w, c, hi, hf, ib, fb;
		bit ival, fval;
		logic [1:0] ctx;
		w = $urandom_range(0, 99);
		// pools running low: lean toward releases
		if ((int_normal < 8 || flt_normal < 8) && w < 45)
			w += 35;
		if (w < 45) begin
			c = $urandom_range(0, 9);
			ctx = (c < 6) ? CTX_NORMAL : (c < 8) ? CTX_RESERVED : CTX_EXCLUSIVE;
			return alloc_cmd(ctx, request_size(), request_size());
		end
		if (w < 80) begin
			hi = pick_head(1'b0);
			hf = pick_head(1'b1);
			ival = hi >= 0 && $urandom_range(0, 3) != 0;
			fval = hf >= 0 && $urandom_range(0, 3) != 0;
			ib = ival ? hi * INT_BLOCK_REGS : $urandom_range(0, 1023);
			fb = fval ? hf * FLT_BLOCK_REGS : $urandom_range(0, 1023);
			if (ival && $urandom_range(0, 4) == 0)
				ib += $urandom_range(0, INT_BLOCK_REGS - 1);
			if (fval && $urandom_range(0, 4) == 0)
				fb += $urandom_range(0, FLT_BLOCK_REGS - 1);
			ctx = ival ? int_run_ctx[hi] : fval ? flt_run_ctx[hf] : CTX_NORMAL;
			if ($urandom_range(0, 7) == 0)
				ctx = 2'($urandom_range(0, 3));
			return release_cmd(ctx, ib, ival, fb, fval);
		end
		if (w < 88 && int_rsv < 3)
			return reserve_cmd();
		return random_cmd();
	endfunction

	// ---- driving ----

	task automatic send(input rba_in_t it, output rba_out_t outcome);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		outcome = predict_outcome(it);
		expected_results.push_back(outcome);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic release_all();
		rba_out_t e;
		for (int b = 0; b < INT_NBLK; b++)
			if (int_run_len[b] != 0)
				send(release_cmd(int_run_ctx[b], b * INT_BLOCK_REGS, 1'b1, 0, 1'b0), e);
		for (int b = 0; b < FLT_NBLK; b++)
			if (flt_run_len[b] != 0)
				send(release_cmd(flt_run_ctx[b], 0, 1'b0, b * FLT_BLOCK_REGS, 1'b1), e);
	endtask

	// ---- tests ----

	task automatic test_basic_alloc();
		rba_out_t e;
		rba_in_t it;
		send(alloc_cmd(CTX_NORMAL, 1, 0), e);
		send(alloc_cmd(CTX_NORMAL, 0, 0), e);
		send(alloc_cmd(CTX_NORMAL, 0, 33), e);
		// integer side fails first, float must stay untouched
		send(alloc_cmd(CTX_NORMAL, 1024, 32), e);
		send(alloc_cmd(CTX_NORMAL, 2047, 0), e);
		it = alloc_cmd(CTX_UNKNOWN, 32, 32);
		send(it, e);
		it = random_cmd();
		it.func = FUNC_UNKNOWN;
		send(it, e);
	endtask

	task automatic test_context_pools();
		rba_out_t e;
		int xi, xf, ri, rf;
		send(alloc_cmd(CTX_EXCLUSIVE, 32, 32), e);
		xi = e.int_base;
		xf = e.flt_base;
		send(alloc_cmd(CTX_EXCLUSIVE, 32, 0), e);
		send(alloc_cmd(CTX_RESERVED, 0, 64), e);
		send(reserve_cmd(), e);
		send(alloc_cmd(CTX_RESERVED, 64, 64), e);
		ri = e.int_base;
		rf = e.flt_base;
		send(release_cmd(CTX_RESERVED, ri, 1'b1, rf, 1'b1), e);
		send(release_cmd(CTX_EXCLUSIVE, xi, 1'b1, xf, 1'b0), e);
		send(release_cmd(CTX_EXCLUSIVE, xi, 1'b0, xf, 1'b1), e);
	endtask

	task automatic test_release();
		rba_out_t e;
		int hi, hf;
		hi = pick_head(1'b0);
		hf = pick_head(1'b1);
		// exclusive pool already full
		send(release_cmd(CTX_EXCLUSIVE, hi * INT_BLOCK_REGS, 1'b1, 0, 1'b0), e);
		// last block is not a run head
		send(release_cmd(CTX_NORMAL, (INT_NBLK - 1) * INT_BLOCK_REGS, 1'b1, 0, 1'b0), e);
		send(release_cmd(CTX_UNKNOWN, hi * INT_BLOCK_REGS, 1'b1, hf * FLT_BLOCK_REGS, 1'b1), e);
		send(release_cmd(CTX_NORMAL, 0, 1'b0, 0, 1'b0), e);
		// unaligned bases round down to the head block
		send(release_cmd(CTX_NORMAL, hi * INT_BLOCK_REGS + 17, 1'b1,
			hf * FLT_BLOCK_REGS + FLT_BLOCK_REGS - 1, 1'b1), e);
		release_all();
	endtask

	task automatic test_exhaustion();
		rba_out_t e;
		send(alloc_cmd(CTX_NORMAL, (INT_NBLK - 1) * INT_BLOCK_REGS,
			(FLT_NBLK - 1) * FLT_BLOCK_REGS), e);
		send(reserve_cmd(), e);
		send(alloc_cmd(CTX_NORMAL, 1, 0), e);
		send(alloc_cmd(CTX_EXCLUSIVE, 32, 32), e);
		send(alloc_cmd(CTX_RESERVED, 0, 1), e);
		release_all();
	endtask

	task automatic test_random_traffic();
		rba_out_t e;
		for (int i = 0; i < 450; i++) begin
			if (i == 225)
				wait_drained();
			send(traffic_cmd(), e);
		end
	endtask

	task automatic test_steady_stream();
		rba_out_t e;
		calm = 1'b1;
		for (int i = 0; i < 100; i++)
			send(traffic_cmd(), e);
	endtask

	// ---- result side ----

	always @(posedge clk) begin
		if (calm) begin
			rx_hold <= '0;
			out_ready <= 1'b1;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 3'd1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_hold <= 3'($urandom_range(0, 6));
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		rba_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with nothing pending");
			end else begin
				want = expected_results.pop_front();
				if (out_data.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						out_data.status, want.status));
				if (out_data.int_base !== want.int_base)
					report_mismatch($sformatf("int_base %0d, want %0d",
						out_data.int_base, want.int_base));
				if (out_data.int_base_valid !== want.int_base_valid)
					report_mismatch($sformatf("int_base_valid %0d, want %0d",
						out_data.int_base_valid, want.int_base_valid));
				if (out_data.flt_base !== want.flt_base)
					report_mismatch($sformatf("flt_base %0d, want %0d",
						out_data.flt_base, want.flt_base));
				if (out_data.flt_base_valid !== want.flt_base_valid)
					report_mismatch($sformatf("flt_base_valid %0d, want %0d",
						out_data.flt_base_valid, want.flt_base_valid));
				if (out_data.free_contexts !== want.free_contexts)
					report_mismatch($sformatf("free_contexts %0d, want %0d",
						out_data.free_contexts, want.free_contexts));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		for (int b = 0; b < MAX_NBLK; b++) begin
			int_run_len[b] = '0;
			flt_run_len[b] = '0;
			int_run_ctx[b] = CTX_NORMAL;
			flt_run_ctx[b] = CTX_NORMAL;
		end
		int_normal = INT_NBLK - 1;
		flt_normal = FLT_NBLK - 1;
		int_rsv = 0;
		flt_rsv = 0;
		int_excl = 1;
		flt_excl = 1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_alloc();
		test_context_pools();
		test_release();
		test_exhaustion();
		test_random_traffic();
		test_steady_stream();

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
